@@ rtl/core/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and width helpers for the 3x3 adjugate matrix inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

    // Default entry format is signed Q16.16.
    localparam int ENTRY_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Matrix shape and derived counts.
    localparam int DIM          = 3;
    localparam int NE           = DIM * DIM;
    localparam int FRONT_STAGES = 5;

    // Width of the determinant result port.
    localparam int DET_OUT_W = 64;

    // Next row or column index, wrapping around the matrix.
    function automatic int wrap_idx(input int k);
        return (k >= DIM) ? k - DIM : k;
    endfunction

    // Exact signed cofactor width.
    function automatic int cof_width(input int e);
        return 2 * e + 1;
    endfunction

    // Exact signed determinant width.
    function automatic int det_width(input int e);
        return 3 * e + 3;
    endfunction

    // Width of the rounded division numerator.
    function automatic int num_width(input int e, input int f);
        int a;
        int b;
        a = 2 * e + 2 * f + 2;
        b = det_width(e);
        return ((a > b) ? a : b) + 1;
    endfunction

    // Width of the divider partial remainder.
    function automatic int rem_width(input int e, input int f);
        int a;
        int b;
        a = num_width(e, f);
        b = det_width(e) + e + 1;
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/matrix_inverse_3x3.sv @@
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed fixed-point 3x3 matrix by the adjugate.
// ----------------------------------------------------------------------------
// One matrix enters and one result leaves per clock while the output is not
// stalled; entries default to Q16.16. Five front stages form the cofactors
// and the determinant, nine divider lanes each spend ENTRY_WIDTH+1 stages on
// a restoring division, one quotient bit per stage after the first, and the
// output register merges the lanes. A stage holds its item while the next
// stage is full and cannot move on, so gaps close up under a stalled output.
// A zero determinant gives the singular flag with zero entries and determinant.
`default_nettype none

module matrix_inverse_3x3 #(
    parameter int ENTRY_WIDTH   = mi3_pkg::ENTRY_WIDTH_DEF,
    parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m00,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m01,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m02,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m10,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m11,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m12,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m20,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m21,
    input  wire logic signed [ENTRY_WIDTH-1:0]        m22,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [ENTRY_WIDTH-1:0]             inv00,
    output logic signed [ENTRY_WIDTH-1:0]             inv01,
    output logic signed [ENTRY_WIDTH-1:0]             inv02,
    output logic signed [ENTRY_WIDTH-1:0]             inv10,
    output logic signed [ENTRY_WIDTH-1:0]             inv11,
    output logic signed [ENTRY_WIDTH-1:0]             inv12,
    output logic signed [ENTRY_WIDTH-1:0]             inv20,
    output logic signed [ENTRY_WIDTH-1:0]             inv21,
    output logic signed [ENTRY_WIDTH-1:0]             inv22,
    output logic signed [mi3_pkg::DET_OUT_W-1:0]      determinant,
    output logic                                      singular,
    output logic                                      saturated
);
    import mi3_pkg::*;

    localparam int E    = ENTRY_WIDTH;
    localparam int DW   = det_width(E);
    localparam int NUMW = num_width(E, FRACTION_BITS);
    localparam int FS   = FRONT_STAGES;
    localparam int DS   = E + 1;
    localparam int NS   = FS + DS + 1;

    logic [NS-1:0]         v_reg;
    logic [NS-1:0]         v_next;
    logic [NS-1:0]         en;

    logic signed [E-1:0]   m_in [NE];
    logic [NUMW-1:0]       f_num [NE];
    logic [DW-1:0]         f_den;
    logic                  f_neg [NE];
    logic                  f_sing;
    logic signed [DET_OUT_W-1:0] f_det;

    logic signed [E-1:0]   lane_val [NE];
    logic [NE-1:0]         lane_sat;

    logic                  sing_pipe_reg [DS];
    logic signed [DET_OUT_W-1:0] det_pipe_reg [DS];

    logic signed [E-1:0]   inv_reg [NE];
    logic signed [DET_OUT_W-1:0] det_reg;
    logic                  sing_reg;
    logic                  sat_reg;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                v_next[k] = (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    // Matrix entries in row-major order.
    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    mi3_front #(
        .ENTRY_WIDTH   (ENTRY_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .en       (en[FS-1:0]),
        .m        (m_in),
        .num      (f_num),
        .den      (f_den),
        .neg      (f_neg),
        .singular (f_sing),
        .det_out  (f_det)
    );

    // Nine divider lanes, one per inverse entry.
    for (genvar i = 0; i < NE; i++)
    begin : g_lane
        mi3_div_lane #(
            .ENTRY_WIDTH   (ENTRY_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .clk (clk),
            .en  (en[FS+DS-1:FS]),
            .num (f_num[i]),
            .den (f_den),
            .neg (f_neg[i]),
            .val (lane_val[i]),
            .sat (lane_sat[i])
        );
    end

    // Singular flag and determinant travel beside the lanes.
    always_ff @(posedge clk)
    begin
        if (en[FS])
        begin
            sing_pipe_reg[0] <= f_sing;
            det_pipe_reg[0]  <= f_det;
        end
        for (int j = 1; j < DS; j++)
        begin
            if (en[FS+j])
            begin
                sing_pipe_reg[j] <= sing_pipe_reg[j-1];
                det_pipe_reg[j]  <= det_pipe_reg[j-1];
            end
        end
    end

    // Merge the lanes into the output register.
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            for (int i = 0; i < NE; i++)
            begin
                inv_reg[i] <= sing_pipe_reg[DS-1] ? '0 : lane_val[i];
            end
            det_reg  <= sing_pipe_reg[DS-1] ? '0 : det_pipe_reg[DS-1];
            sing_reg <= sing_pipe_reg[DS-1];
            sat_reg  <= !sing_pipe_reg[DS-1] && (|lane_sat);
        end
    end

    assign inv00       = inv_reg[0];
    assign inv01       = inv_reg[1];
    assign inv02       = inv_reg[2];
    assign inv10       = inv_reg[3];
    assign inv11       = inv_reg[4];
    assign inv12       = inv_reg[5];
    assign inv20       = inv_reg[6];
    assign inv21       = inv_reg[7];
    assign inv22       = inv_reg[8];
    assign determinant = det_reg;
    assign singular    = sing_reg;
    assign saturated   = sat_reg;

    // A singular result carries a zero determinant and no clipping.
    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> determinant == '0 && !saturated && inv00 == '0)
        else $error("singular result with nonzero fields");

    // Input backpressure only comes from a full, stalled pipeline.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && (&v_reg))
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

@@ rtl/core/mi3_front.sv @@
// ----------------------------------------------------------------------------
// mi3_front
// Cofactor products, determinant expansion and divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_front #(
    parameter int ENTRY_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                          clk,
    input  wire logic [mi3_pkg::FRONT_STAGES-1:0]              en,
    input  wire logic signed [ENTRY_WIDTH-1:0]                 m [mi3_pkg::NE],
    output logic [mi3_pkg::num_width(ENTRY_WIDTH, FRACTION_BITS)-1:0] num [mi3_pkg::NE],
    output logic [mi3_pkg::det_width(ENTRY_WIDTH)-1:0]         den,
    output logic                                               neg [mi3_pkg::NE],
    output logic                                               singular,
    output logic signed [mi3_pkg::DET_OUT_W-1:0]               det_out
);
    import mi3_pkg::*;

    localparam int E    = ENTRY_WIDTH;
    localparam int PW   = 2 * E;
    localparam int CW   = cof_width(E);
    localparam int HW   = CW - E;
    localparam int QW   = 2 * E + 1;
    localparam int DW   = det_width(E);
    localparam int NUMW = num_width(E, FRACTION_BITS);
    localparam int XW   = (DW > DET_OUT_W) ? DW : DET_OUT_W + 1;

    logic signed [PW-1:0] pa_reg [NE];
    logic signed [PW-1:0] pb_reg [NE];
    logic signed [PW-1:0] pa_next [NE];
    logic signed [PW-1:0] pb_next [NE];
    logic signed [E-1:0]  m0_s0_reg [DIM];
    logic signed [E-1:0]  m0_s1_reg [DIM];
    logic signed [CW-1:0] cof_reg [NE];
    logic signed [CW-1:0] cof_s2_reg [NE];
    logic signed [CW-1:0] cof_s3_reg [NE];
    logic signed [QW-1:0] lo_reg [DIM];
    logic signed [QW-1:0] hi_reg [DIM];
    logic signed [QW-1:0] lo_next [DIM];
    logic signed [QW-1:0] hi_next [DIM];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    logic [NUMW-1:0]      num_next [NE];
    logic                 neg_next [NE];
    logic [CW-1:0]        cof_abs;
    logic [DW-1:0]        det_abs;
    logic signed [XW-1:0] det_shift;
    logic                 det_fits;
    logic signed [DET_OUT_W-1:0] det_out_next;

    // Two products per cofactor, taken from the rows and columns that wrap around.
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                pa_next[r*DIM+c] = m[wrap_idx(r+1)*DIM + wrap_idx(c+1)]
                                 * m[wrap_idx(r+2)*DIM + wrap_idx(c+2)];
                pb_next[r*DIM+c] = m[wrap_idx(r+1)*DIM + wrap_idx(c+2)]
                                 * m[wrap_idx(r+2)*DIM + wrap_idx(c+1)];
            end
        end
    end

    // Determinant partial products, the cofactor split into low and high halves.
    always_comb
    begin
        for (int c = 0; c < DIM; c++)
        begin
            lo_next[c] = m0_s1_reg[c] * $signed({1'b0, cof_reg[c][E-1:0]});
            hi_next[c] = m0_s1_reg[c] * $signed(cof_reg[c][CW-1:E]);
        end
    end

    // Sum of the first-row expansion.
    always_comb
    begin
        det_next = '0;
        for (int c = 0; c < DIM; c++)
        begin
            det_next = det_next + (DW'(hi_reg[c]) <<< E) + DW'(lo_reg[c]);
        end
    end

    // Divider operands; lane r*DIM+c takes the transposed cofactor.
    always_comb
    begin
        det_abs = det_reg[DW-1] ? (~det_reg + 1'b1) : det_reg;
        cof_abs = '0;
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                cof_abs = cof_s3_reg[c*DIM+r][CW-1] ? (~cof_s3_reg[c*DIM+r] + 1'b1)
                                                    : cof_s3_reg[c*DIM+r];
                num_next[r*DIM+c] = (NUMW'(cof_abs) << (2*FRACTION_BITS + 1))
                                  + NUMW'(det_abs);
                neg_next[r*DIM+c] = cof_s3_reg[c*DIM+r][CW-1] ^ det_reg[DW-1];
            end
        end
    end

    // Determinant in the output format, clipped to the port range.
    always_comb
    begin
        det_shift = XW'(det_reg) >>> (2*FRACTION_BITS);
        det_fits  = (&det_shift[XW-1:DET_OUT_W-1]) | ~(|det_shift[XW-1:DET_OUT_W-1]);
        if (det_fits)
        begin
            det_out_next = det_shift[DET_OUT_W-1:0];
        end
        else
        begin
            det_out_next = det_reg[DW-1] ? {1'b1, {(DET_OUT_W-1){1'b0}}}
                                         : {1'b0, {(DET_OUT_W-1){1'b1}}};
        end
    end

    // Stage registers, each advancing on its own enable.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            for (int c = 0; c < DIM; c++)
            begin
                m0_s0_reg[c] <= m[c];
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < NE; i++)
            begin
                cof_reg[i] <= CW'(pa_reg[i]) - CW'(pb_reg[i]);
            end
            m0_s1_reg <= m0_s0_reg;
        end
        if (en[2])
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            cof_s2_reg <= cof_reg;
        end
        if (en[3])
        begin
            det_reg    <= det_next;
            cof_s3_reg <= cof_s2_reg;
        end
        if (en[4])
        begin
            num      <= num_next;
            neg      <= neg_next;
            den      <= {det_abs[DW-2:0], 1'b0};
            singular <= (det_reg == '0);
            det_out  <= det_out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mi3_div_lane.sv @@
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider for one inverse entry, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_lane #(
    parameter int ENTRY_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                                  clk,
    input  wire logic [ENTRY_WIDTH:0]                                  en,
    input  wire logic [mi3_pkg::num_width(ENTRY_WIDTH, FRACTION_BITS)-1:0] num,
    input  wire logic [mi3_pkg::det_width(ENTRY_WIDTH)-1:0]            den,
    input  wire logic                                                  neg,
    output logic signed [ENTRY_WIDTH-1:0]                              val,
    output logic                                                       sat
);
    import mi3_pkg::*;

    localparam int E  = ENTRY_WIDTH;
    localparam int DW = det_width(E);
    localparam int RW = rem_width(E, FRACTION_BITS);

    logic [RW-1:0] rem_reg [E+1];
    logic [DW-1:0] den_reg [E+1];
    logic [E-1:0]  q_reg   [E+1];
    logic          neg_reg [E+1];
    logic          ovf_reg [E+1];

    logic [E-1:0]  half;
    logic [E-1:0]  q_sat;

    // First stage: a quotient of 2^E or more always saturates.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (RW'(num) >= (RW'(den) << E));
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= E; j++)
    begin : g_step
        logic [RW-1:0] trial;
        logic          ge;

        always_comb
        begin
            trial = RW'(den_reg[j-1]) << (E - j);
            ge    = (rem_reg[j-1] >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (ge ? (E'(1) << (E - j)) : '0);
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // Clip the magnitude to the signed range and apply the sign.
    always_comb
    begin
        half  = E'(1) << (E - 1);
        q_sat = q_reg[E];
        if (neg_reg[E])
        begin
            sat = ovf_reg[E] || (q_reg[E] > half) || (rem_reg[E] == '0 && 1'b0)
                  || (den_reg[E] == '0 && 1'b0);
            if (sat)
            begin
                q_sat = half;
            end
            val = -q_sat;
        end
        else
        begin
            sat = ovf_reg[E] || q_reg[E][E-1];
            val = sat ? {1'b0, {(E-1){1'b1}}} : q_reg[E];
        end
    end

endmodule

`default_nettype wire
